>>> hdl/keystroke_card_number_framer_defines.svh
// Assertion macros used by the checker file.
`ifndef KEYSTROKE_CARD_NUMBER_FRAMER_DEFINES_SVH
`define KEYSTROKE_CARD_NUMBER_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KCNF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define KCNF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/kcnf_pkg.sv
`timescale 1ns / 1ps
package kcnf_pkg;

   localparam int MAX_DIGITS_DEFAULT = 32;

   localparam logic [7:0]  KEY_ZERO    = 8'h30;
   localparam logic [7:0]  KEY_NINE    = 8'h39;
   localparam logic [7:0]  KEY_CR      = 8'h0D;
   localparam logic [15:0] SPAN_RESET  = 16'd100;
   localparam logic [5:0]  COUNT_RESET = 6'd10;

   localparam int SPAN_W  = 16;
   localparam int COUNT_W = 6;
   localparam int TIME_W  = 32;
   localparam int ALU_W   = TIME_W + 1;

   typedef enum logic [0:0] {
      CSR_MAX_SPAN,
      CSR_MAX_COUNT
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAP,
      ST_SPAN,
      ST_LIMIT,
      ST_EMIT,
      ST_EMPTY
   } state_type;

endpackage

>>> hdl/kcnf_alu.sv
`timescale 1ns / 1ps
module kcnf_alu (
   input  logic [kcnf_pkg::ALU_W-1:0] op_a,
   input  logic [kcnf_pkg::ALU_W-1:0] op_b,
   output logic [kcnf_pkg::ALU_W-1:0] diff,
   output logic                       borrow
);
   import kcnf_pkg::*;

   // Shared subtractor: gap computation and both window compares.
   assign diff   = op_a - op_b;
   assign borrow = diff[ALU_W-1];

endmodule

>>> hdl/kcnf_buffer.sv
`timescale 1ns / 1ps
module kcnf_buffer #(
   parameter int DEPTH = kcnf_pkg::MAX_DIGITS_DEFAULT,
   parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [IW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   import kcnf_pkg::*;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/keystroke_card_number_framer.sv
`timescale 1ns / 1ps
// A digit or other key keeps the block busy through accept, gap and window check.
// A carriage return adds the late-card check; an accepted card shows its first result
// in ST_EMIT or ST_EMPTY, then one result per cycle unless stalled, and a card of
// n results (an empty card gives one) holds the block until its last result is taken.
// All steps share one 33-bit subtractor; the digit store has one read and one write port.
// Reset (synchronous, active high) clears count, overflow mark, last key time; limits 100/10.
module keystroke_card_number_framer #(
   parameter int MAX_DIGITS = kcnf_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_key_code,
   input  logic [31:0]           req_key_time,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_card_char,
   output logic                  rsp_card_empty,
   output logic                  rsp_last_char,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  kcnf_pkg::csr_index_type csr_index,
   input  logic [15:0]           csr_data
);
   import kcnf_pkg::*;

   localparam int IW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CW   = $clog2(MAX_DIGITS + 1);
   localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

   state_type            state_ff, state_in;
   logic [7:0]           code_ff;
   logic [TIME_W-1:0]    time_ff;
   logic [TIME_W-1:0]    gap_ff, gap_in;
   logic [TIME_W-1:0]    last_ff, last_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [IW-1:0]        k_ff, k_in;
   logic [SPAN_W-1:0]    span_ff;
   logic [COUNT_W-1:0]   maxcnt_ff;

   logic [ALU_W-1:0]     alu_a, alu_b, alu_diff;
   logic                 alu_borrow;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr, rd_addr;
   logic [7:0]           rd_data;
   logic                 is_digit, is_cr, emit_last, cnt_ok, rsp_take;

   kcnf_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .diff   (alu_diff),
      .borrow (alu_borrow)
   );

   kcnf_buffer #(
      .DEPTH (MAX_DIGITS),
      .IW    (IW)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (code_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff   <= SPAN_RESET;
         maxcnt_ff <= COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_SPAN:  span_ff   <= csr_data;
            CSR_MAX_COUNT: maxcnt_ff <= csr_data[COUNT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         code_ff <= req_key_code;
         time_ff <= req_key_time;
      end
      gap_ff <= gap_in;
   end

   assign is_digit  = (code_ff >= KEY_ZERO) && (code_ff <= KEY_NINE);
   assign is_cr     = (code_ff == KEY_CR);
   assign cnt_ok    = CMPW'(count_ff) <= CMPW'(maxcnt_ff);
   assign emit_last = (CW'(k_ff) + CW'(1)) == count_ff;
   assign rsp_take  = rsp_valid && !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      gap_in    = gap_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      k_in      = k_ff;
      alu_a     = {1'b0, time_ff};
      alu_b     = {1'b0, last_ff};
      wr_en     = 1'b0;
      wr_addr   = count_ff[IW-1:0];
      rd_addr   = k_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_GAP;
            end
         end
         ST_GAP: begin
            // gap wraps modulo 2^32
            gap_in   = alu_diff[TIME_W-1:0];
            last_in  = time_ff;
            state_in = ST_SPAN;
         end
         ST_SPAN: begin
            // borrow of span - gap: gap longer than max_span
            alu_a = {{(ALU_W - SPAN_W){1'b0}}, span_ff};
            alu_b = {1'b0, gap_ff};
            priority if (is_digit) begin
               state_in = ST_IDLE;
               if (alu_borrow) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  count_in = CW'(1);
                  ovf_in   = 1'b0;
               end else if (count_ff < CW'(MAX_DIGITS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end else if (is_cr) begin
               state_in = ST_LIMIT;
            end else begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_LIMIT: begin
            // borrow of 2*span - gap: card arrived too late
            alu_a   = {{(ALU_W - SPAN_W - 1){1'b0}}, span_ff, 1'b0};
            alu_b   = {1'b0, gap_ff};
            rd_addr = '0;
            k_in    = '0;
            if (!alu_borrow && !ovf_ff && cnt_ok) begin
               state_in = (count_ff == '0) ? ST_EMPTY : ST_EMIT;
            end else begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_take) begin
               // prefetch the next digit as this one leaves
               rd_addr = k_ff + IW'(1);
               k_in    = k_ff + IW'(1);
               if (emit_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMPTY: begin
            rsp_valid = 1'b1;
            if (rsp_take) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_card_char  = (state_ff == ST_EMIT) ? rd_data : 8'd0;
   assign rsp_card_empty = (state_ff == ST_EMPTY);
   assign rsp_last_char  = (state_ff == ST_EMPTY) || ((state_ff == ST_EMIT) && emit_last);

endmodule

>>> hdl/kcnf_checker.sv
`timescale 1ns / 1ps
`include "keystroke_card_number_framer_defines.svh"
module kcnf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic [7:0] rsp_card_char,
   input logic       rsp_card_empty,
   input logic       rsp_last_char
);
   import kcnf_pkg::*;

   `KCNF_ASSERT_NOW(a_empty_is_last, clock, reset, rsp_valid && rsp_card_empty, rsp_last_char, "empty card result without last mark")
   `KCNF_ASSERT_NOW(a_empty_char_zero, clock, reset, rsp_valid && rsp_card_empty, rsp_card_char == 8'd0, "empty card result carries a character")
   `KCNF_ASSERT_NOW(a_char_is_digit, clock, reset, rsp_valid && !rsp_card_empty, (rsp_card_char >= KEY_ZERO) && (rsp_card_char <= KEY_NINE), "emitted character is not a digit")
   `KCNF_ASSERT_NEXT(a_busy_after_request, clock, reset, req_valid && !req_stall, req_stall, "request taken while previous one still in work")
   `KCNF_ASSERT_NOW(a_no_request_while_emit, clock, reset, rsp_valid, req_stall, "request channel open while results are pending")

endmodule

bind keystroke_card_number_framer kcnf_checker u_kcnf_checker (.*);
